// ----- design/pco_pkg.sv -----
// ----------------------------------------------------------------------------
// pco_pkg
// Shared constants and types for the polygon convexity/orientation block.
// ----------------------------------------------------------------------------
package pco_pkg;

  localparam int DEF_MAX_VERTICES  = 1024;
  localparam int DEF_COORD_BITS    = 24;
  localparam int VERTEX_TOTAL_BITS = 11;

  // Turn slots carried through the pipeline
  localparam int NUM_TURNS  = 3;
  localparam int TURN_NEW   = 0;  // triple closed by the incoming vertex
  localparam int TURN_WRAPA = 1;  // (v[N-2], v[N-1], v[0])
  localparam int TURN_WRAPB = 2;  // (v[N-1], v[0], v[1])

  typedef struct packed {
    logic                 last;
    logic                 too_many;
    logic [NUM_TURNS-1:0] turn_en;
  } tag_t;

endpackage

// ----- design/pco_front.sv -----
// ----------------------------------------------------------------------------
// pco_front
// Vertex history, counting and operand differences for up to three turns.
// ----------------------------------------------------------------------------
module pco_front
  import pco_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int COORD_BITS   = DEF_COORD_BITS,
  localparam int NW = $clog2(MAX_VERTICES + 1),
  localparam int DW = COORD_BITS + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                         last_vertex,
  output logic                         diff_valid,
  input  logic                         diff_ready,
  output logic signed [DW-1:0]         dx0 [NUM_TURNS],
  output logic signed [DW-1:0]         dy0 [NUM_TURNS],
  output logic signed [DW-1:0]         dx1 [NUM_TURNS],
  output logic signed [DW-1:0]         dy1 [NUM_TURNS],
  output tag_t                         diff_tag,
  output logic [NW-1:0]                diff_count
);

  logic signed [COORD_BITS-1:0] first_x, first_y, second_x, second_y;
  logic signed [COORD_BITS-1:0] older_x, older_y, newer_x, newer_y;
  logic [NW-1:0]                vertex_count;
  logic                         overflow_seen;

  logic                         keep;
  logic                         accept;
  logic [NW-1:0]                count_next;
  logic                         wrap_en;
  logic signed [COORD_BITS-1:0] ax [NUM_TURNS];
  logic signed [COORD_BITS-1:0] ay [NUM_TURNS];
  logic signed [COORD_BITS-1:0] bx [NUM_TURNS];
  logic signed [COORD_BITS-1:0] by [NUM_TURNS];
  logic signed [COORD_BITS-1:0] cx [NUM_TURNS];
  logic signed [COORD_BITS-1:0] cy [NUM_TURNS];

  assign in_ready   = !diff_valid || diff_ready;
  assign accept     = in_valid && in_ready;
  assign keep       = vertex_count < NW'(MAX_VERTICES);
  assign count_next = vertex_count + NW'(keep);
  assign wrap_en    = last_vertex && (count_next >= NW'(3));

  // Pick the three triples; a dropped vertex leaves the history as it was
  always_comb begin
    ax[TURN_NEW] = older_x;  ay[TURN_NEW] = older_y;
    bx[TURN_NEW] = newer_x;  by[TURN_NEW] = newer_y;
    cx[TURN_NEW] = vertex_x; cy[TURN_NEW] = vertex_y;
    if (keep) begin
      ax[TURN_WRAPA] = newer_x;  ay[TURN_WRAPA] = newer_y;
      bx[TURN_WRAPA] = vertex_x; by[TURN_WRAPA] = vertex_y;
      ax[TURN_WRAPB] = vertex_x; ay[TURN_WRAPB] = vertex_y;
    end else begin
      ax[TURN_WRAPA] = older_x;  ay[TURN_WRAPA] = older_y;
      bx[TURN_WRAPA] = newer_x;  by[TURN_WRAPA] = newer_y;
      ax[TURN_WRAPB] = newer_x;  ay[TURN_WRAPB] = newer_y;
    end
    cx[TURN_WRAPA] = first_x;  cy[TURN_WRAPA] = first_y;
    bx[TURN_WRAPB] = first_x;  by[TURN_WRAPB] = first_y;
    cx[TURN_WRAPB] = second_x; cy[TURN_WRAPB] = second_y;
  end

  // History and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (last_vertex) begin
        vertex_count  <= '0;
        overflow_seen <= 1'b0;
      end else if (keep) begin
        vertex_count <= count_next;
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      if (vertex_count == '0) begin
        first_x <= vertex_x;
        first_y <= vertex_y;
      end
      if (vertex_count == NW'(1)) begin
        second_x <= vertex_x;
        second_y <= vertex_y;
      end
      older_x <= newer_x;
      older_y <= newer_y;
      newer_x <= vertex_x;
      newer_y <= vertex_y;
    end
  end

  // Stage register: differences about the middle vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
    end else if (in_ready) begin
      diff_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NUM_TURNS; i++) begin
        dx0[i] <= DW'(ax[i]) - DW'(bx[i]);
        dy0[i] <= DW'(ay[i]) - DW'(by[i]);
        dx1[i] <= DW'(cx[i]) - DW'(bx[i]);
        dy1[i] <= DW'(cy[i]) - DW'(by[i]);
      end
      diff_tag.last                <= last_vertex;
      diff_tag.too_many            <= overflow_seen || !keep;
      diff_tag.turn_en[TURN_NEW]   <= keep && (vertex_count >= NW'(2));
      diff_tag.turn_en[TURN_WRAPA] <= wrap_en;
      diff_tag.turn_en[TURN_WRAPB] <= wrap_en;
      diff_count                   <= count_next;
    end
  end

endmodule

// ----- design/pco_cross.sv -----
// ----------------------------------------------------------------------------
// pco_cross
// Partial products of the three cross products, one register stage.
// ----------------------------------------------------------------------------
module pco_cross
  import pco_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int COORD_BITS   = DEF_COORD_BITS,
  localparam int NW = $clog2(MAX_VERTICES + 1),
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 diff_valid,
  output logic                 diff_ready,
  input  logic signed [DW-1:0] dx0 [NUM_TURNS],
  input  logic signed [DW-1:0] dy0 [NUM_TURNS],
  input  logic signed [DW-1:0] dx1 [NUM_TURNS],
  input  logic signed [DW-1:0] dy1 [NUM_TURNS],
  input  tag_t                 diff_tag,
  input  logic [NW-1:0]        diff_count,
  output logic                 prod_valid,
  input  logic                 prod_ready,
  output logic signed [PW-1:0] prod_a [NUM_TURNS],
  output logic signed [PW-1:0] prod_b [NUM_TURNS],
  output tag_t                 prod_tag,
  output logic [NW-1:0]        prod_count
);

  assign diff_ready = !prod_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (diff_ready) begin
      prod_valid <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (diff_valid && diff_ready) begin
      for (int i = 0; i < NUM_TURNS; i++) begin
        prod_a[i] <= PW'(dx0[i]) * PW'(dy1[i]);
        prod_b[i] <= PW'(dy0[i]) * PW'(dx1[i]);
      end
      prod_tag   <= diff_tag;
      prod_count <= diff_count;
    end
  end

endmodule

// ----- design/pco_tally.sv -----
// ----------------------------------------------------------------------------
// pco_tally
// Turn sign test, positive-turn accumulation and the result register.
// ----------------------------------------------------------------------------
module pco_tally
  import pco_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int COORD_BITS   = DEF_COORD_BITS,
  localparam int NW = $clog2(MAX_VERTICES + 1),
  localparam int DW = COORD_BITS + 1,
  localparam int PW = 2 * DW
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         prod_valid,
  output logic                         prod_ready,
  input  logic signed [PW-1:0]         prod_a [NUM_TURNS],
  input  logic signed [PW-1:0]         prod_b [NUM_TURNS],
  input  tag_t                         prod_tag,
  input  logic [NW-1:0]                prod_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         is_convex,
  output logic                         is_ccw,
  output logic                         too_many,
  output logic [VERTEX_TOTAL_BITS-1:0] vertex_total
);

  logic                 take;
  logic [NUM_TURNS-1:0] positive;
  logic signed [PW:0]   z [NUM_TURNS];
  logic [NW-1:0]        positive_count;
  logic [NW-1:0]        pos_total;

  // Non-final vertices never touch the result register
  assign prod_ready = !prod_valid || !prod_tag.last || !out_valid || out_ready;
  assign take       = prod_valid && prod_ready;

  always_comb begin
    for (int i = 0; i < NUM_TURNS; i++) begin
      z[i]        = (PW + 1)'(prod_a[i]) - (PW + 1)'(prod_b[i]);
      positive[i] = prod_tag.turn_en[i] && (z[i] > 0);
    end
    pos_total = positive_count + NW'(positive[TURN_NEW]) + NW'(positive[TURN_WRAPA])
              + NW'(positive[TURN_WRAPB]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      positive_count <= '0;
    end else if (take) begin
      positive_count <= prod_tag.last ? '0 : pos_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && prod_tag.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && prod_tag.last) begin
      is_convex    <= (pos_total == '0) || (pos_total == prod_count);
      is_ccw       <= {pos_total, 1'b0} < {1'b0, prod_count};
      too_many     <= prod_tag.too_many;
      vertex_total <= VERTEX_TOTAL_BITS'(prod_count);
    end
  end

endmodule

// ----- design/polygon_convexity_orientation.sv -----
// ----------------------------------------------------------------------------
// polygon_convexity_orientation
// Convexity and winding test of a polygon streamed one vertex per transfer.
// ----------------------------------------------------------------------------
// Input channel: one vertex per transfer (vertex_x, vertex_y in signed Q16.8,
// last_vertex on the final one). Output channel: one result per polygon,
// sent after the transfer that carries last_vertex.
//
// Three register stages: operand differences, cross-product partial
// products, then sign test / count and the result register. out_valid rises
// from the result register once the final vertex has passed the difference
// and product registers. One vertex is taken every cycle while in_ready is
// high; the rate is set by the single pass through the multiplier stage.
//
// Vertices arriving after MAX_VERTICES are held are dropped and reported
// through too_many. Reset clears the vertex count, the positive count,
// the drop flag and all stage valids; stored coordinates keep their value.
// When the receiver stalls with a result pending, non-final vertices keep
// flowing and are counted; a second final vertex waits in the product
// stage, and in_ready falls once the stages behind it fill.
// ----------------------------------------------------------------------------
module polygon_convexity_orientation
  import pco_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                         last_vertex,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         is_convex,
  output logic                         is_ccw,
  output logic                         too_many,
  output logic [VERTEX_TOTAL_BITS-1:0] vertex_total
);

  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic                 diff_valid, diff_ready;
  logic signed [DW-1:0] dx0 [NUM_TURNS];
  logic signed [DW-1:0] dy0 [NUM_TURNS];
  logic signed [DW-1:0] dx1 [NUM_TURNS];
  logic signed [DW-1:0] dy1 [NUM_TURNS];
  tag_t                 diff_tag;
  logic [NW-1:0]        diff_count;

  logic                 prod_valid, prod_ready;
  logic signed [PW-1:0] prod_a [NUM_TURNS];
  logic signed [PW-1:0] prod_b [NUM_TURNS];
  tag_t                 prod_tag;
  logic [NW-1:0]        prod_count;

  // Track history, select the turn triples, take differences
  pco_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .last_vertex (last_vertex),
    .diff_valid  (diff_valid),
    .diff_ready  (diff_ready),
    .dx0         (dx0),
    .dy0         (dy0),
    .dx1         (dx1),
    .dy1         (dy1),
    .diff_tag    (diff_tag),
    .diff_count  (diff_count)
  );

  // Form both partial products of each cross product
  pco_cross #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_cross (
    .clk        (clk),
    .rst        (rst),
    .diff_valid (diff_valid),
    .diff_ready (diff_ready),
    .dx0        (dx0),
    .dy0        (dy0),
    .dx1        (dx1),
    .dy1        (dy1),
    .diff_tag   (diff_tag),
    .diff_count (diff_count),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_a     (prod_a),
    .prod_b     (prod_b),
    .prod_tag   (prod_tag),
    .prod_count (prod_count)
  );

  // Count positive turns and hold the verdict until transfer
  pco_tally #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_tally (
    .clk          (clk),
    .rst          (rst),
    .prod_valid   (prod_valid),
    .prod_ready   (prod_ready),
    .prod_a       (prod_a),
    .prod_b       (prod_b),
    .prod_tag     (prod_tag),
    .prod_count   (prod_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_convex    (is_convex),
    .is_ccw       (is_ccw),
    .too_many     (too_many),
    .vertex_total (vertex_total)
  );

endmodule
